/* rtl/two_level_adaptive_branch_predictor_core_macros.svh */
// Assertion macros shared by the branch predictor checker.
// Depends on nothing; take in by `include where concurrent assertions are written.
`ifndef TWO_LEVEL_ADAPTIVE_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define TWO_LEVEL_ADAPTIVE_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Same-cycle implication on the rising clock edge.
`define TLABP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the rising clock edge.
`define TLABP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tlabp_pkg.sv */
// Shared types and constants of the two-level adaptive branch predictor.
// Used by the controller, the datapath and the top level; depends on nothing.
package tlabp_pkg;

   // Field widths fixed by the interface
   localparam int PC_FIELD_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int HB_W       = 4;
   localparam int HIB_W      = 3;
   localparam int PIB_W      = 3;
   localparam int ALIAS_W    = 2;

   // Parameter defaults
   localparam int HIST_INDEX_MAX_DEF = 6;
   localparam int PAT_INDEX_MAX_DEF  = 4;
   localparam int HIST_MAX_DEF       = 8;
   localparam int PC_WIDTH_DEF       = 64;

   // Register reset values
   localparam logic [HB_W-1:0]    HB_RESET    = 4'd8;
   localparam logic [HIB_W-1:0]   HIB_RESET   = 3'd0;
   localparam logic [PIB_W-1:0]   PIB_RESET   = 3'd0;
   localparam logic [ALIAS_W-1:0] ALIAS_RESET = 2'd0;

   // History aliasing in the global-global case
   localparam logic [ALIAS_W-1:0] ALIAS_XOR = 2'd1;
   localparam logic [ALIAS_W-1:0] ALIAS_AND = 2'd2;

   // Saturating counter limits
   localparam logic [1:0] CNT_MAX     = 2'd3;
   localparam logic [1:0] CNT_WEAK_NT = 2'd1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_UPDATE = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HISTORY_BITS       = 2'd0,
      CSR_HISTORY_INDEX_BITS = 2'd1,
      CSR_PATTERN_INDEX_BITS = 2'd2,
      CSR_ALIAS_SELECT       = 2'd3
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic sweep_clear;
      logic sweep_step;
      logic clear_all;
      logic alloc_write;
      logic row_clear;
      logic exec_update;
      logic out_load;
      logic out_lookup;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pat_global;
      logic sweep_last;
      logic row_last;
   } dp_status_type;

endpackage

/* rtl/two_level_adaptive_branch_predictor_core.sv */
// Top level of the two-level adaptive branch predictor (GAg, GAp, PAg, PAp).
// Depends on tlabp_pkg, tlabp_ctrl and tlabp_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_op, req_pc, req_taken
//   rsp      out        rsp_valid / rsp_ready  rsp_hit, rsp_predict_taken
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Lookup and update go from accept through a history and tag read, a counter read
// and an execute step, the reads each through a registered memory port.
// Allocate writes the tag and history entries, then, unless the pattern table is
// global, clears the counter row one entry per cycle; flush clears 2**SW entries,
// where SW = max(history index width, pattern index width + HISTORY_MAX).
// After reset a clearing pass over 2**SW entries (4096 by default) runs with req_ready low.
// A finished result waits in the output register while the next beat is accepted;
// an item only stalls at its last step while that register is still full.
module two_level_adaptive_branch_predictor_core import tlabp_pkg::*; #(
   parameter int HISTORY_INDEX_MAX = HIST_INDEX_MAX_DEF,
   parameter int PATTERN_INDEX_MAX = PAT_INDEX_MAX_DEF,
   parameter int HISTORY_MAX       = HIST_MAX_DEF,
   parameter int PC_WIDTH          = PC_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [PC_FIELD_W-1:0] req_pc,
   input  logic                  req_taken,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic                  rsp_predict_taken,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tlabp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlabp_datapath #(
      .HISTORY_INDEX_MAX (HISTORY_INDEX_MAX),
      .PATTERN_INDEX_MAX (PATTERN_INDEX_MAX),
      .HISTORY_MAX       (HISTORY_MAX),
      .PC_WIDTH          (PC_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_pc            (req_pc),
      .req_taken         (req_taken),
      .cmd               (cmd),
      .status            (status),
      .rsp_hit           (rsp_hit),
      .rsp_predict_taken (rsp_predict_taken)
   );

endmodule

/* rtl/tlabp_ctrl.sv */
// Sequencing controller of the branch predictor: operation decode, table sweeps
// and the result handshake. Depends on tlabp_pkg.
module tlabp_ctrl import tlabp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_op,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_HREAD  = 9'b000000100,
      S_CREAD  = 9'b000001000,
      S_EXEC   = 9'b000010000,
      S_ALLOC  = 9'b000100000,
      S_ROWCLR = 9'b001000000,
      S_FLUSH  = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff;
   op_type    req_op_t;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   assign req_op_t  = op_type'(req_op);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_all  = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load_item   = 1'b1;
               cmd.sweep_clear = 1'b1;
               unique case (req_op_t) inside
                  OP_LOOKUP, OP_UPDATE: state_in = S_HREAD;
                  OP_ALLOC:             state_in = S_ALLOC;
                  OP_FLUSH:             state_in = S_FLUSH;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_HREAD: state_in = S_CREAD;
         S_CREAD: state_in = S_EXEC;
         S_EXEC: begin
            if (out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_lookup  = (op_ff == OP_LOOKUP);
               cmd.exec_update = (op_ff == OP_UPDATE);
               state_in        = S_IDLE;
            end
         end
         S_ALLOC: begin
            cmd.alloc_write = 1'b1;
            state_in = status.pat_global ? S_DONE : S_ROWCLR;
         end
         S_ROWCLR: begin
            cmd.row_clear  = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.row_last) begin
               state_in = S_DONE;
            end
         end
         S_FLUSH: begin
            cmd.clear_all  = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Advance state; start every reset with a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff    <= OP_LOOKUP;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            op_ff <= req_op_t;
         end
      end
   end

   // Hold the result beat until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

/* rtl/tlabp_datapath.sv */
// Datapath of the branch predictor: configuration registers, history, tag and
// counter memories, index logic and the result register. Depends on tlabp_pkg.
module tlabp_datapath import tlabp_pkg::*; #(
   parameter int HISTORY_INDEX_MAX = HIST_INDEX_MAX_DEF,
   parameter int PATTERN_INDEX_MAX = PAT_INDEX_MAX_DEF,
   parameter int HISTORY_MAX       = HIST_MAX_DEF,
   parameter int PC_WIDTH          = PC_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [PC_FIELD_W-1:0] req_pc,
   input  logic                  req_taken,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_hit,
   output logic                  rsp_predict_taken
);

   localparam int HIW      = (HISTORY_INDEX_MAX > 0) ? HISTORY_INDEX_MAX : 1;
   localparam int PIW      = (PATTERN_INDEX_MAX > 0) ? PATTERN_INDEX_MAX : 1;
   localparam int HM       = HISTORY_MAX;
   localparam int CAW      = PIW + HM;
   localparam int SAW      = (HIW > CAW) ? HIW : CAW;
   localparam int HT_DEPTH = 1 << HIW;
   localparam int PT_DEPTH = 1 << PIW;
   localparam int CT_DEPTH = 1 << CAW;

   // Configuration registers
   logic [HB_W-1:0]    hist_bits_ff;
   logic [HIB_W-1:0]   hist_idx_bits_ff;
   logic [PIB_W-1:0]   pat_idx_bits_ff;
   logic [ALIAS_W-1:0] alias_ff;

   // Item and read registers
   logic [PC_WIDTH-1:0] pc_ff;
   logic                taken_ff;
   logic [HM-1:0]       hist_rd_ff;
   logic [PC_WIDTH-1:0] htag_rd_ff;
   logic [PC_WIDTH-1:0] ptag_rd_ff;
   logic [1:0]          cnt_rd_ff;
   logic [CAW-1:0]      cnt_addr_ff;
   logic [SAW-1:0]      sweep_ff;
   logic                hit_ff;
   logic                pred_ff;

   // Memories
   logic [HM-1:0]       hist_mem [HT_DEPTH];
   logic [PC_WIDTH-1:0] htag_mem [HT_DEPTH];
   logic [PC_WIDTH-1:0] ptag_mem [PT_DEPTH];
   logic [1:0]          cnt_mem  [CT_DEPTH];

   // Derived values
   logic [HIW-1:0] hidx;
   logic [PIW-1:0] pidx;
   logic [HM-1:0]  hmask;
   logic [HM-1:0]  hist_masked;
   logic [HM-1:0]  cidx;
   logic [CAW-1:0] cnt_addr;
   logic [CAW-1:0] row_addr;
   logic [HM-1:0]  hist_new;
   logic [1:0]     cnt_new;
   logic           hg;
   logic           pg;
   logic           hit;
   logic           pred;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_bits_ff     <= HB_RESET;
         hist_idx_bits_ff <= HIB_RESET;
         pat_idx_bits_ff  <= PIB_RESET;
         alias_ff         <= ALIAS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HISTORY_BITS:       hist_bits_ff     <= csr_wdata[HB_W-1:0];
            CSR_HISTORY_INDEX_BITS: hist_idx_bits_ff <= csr_wdata[HIB_W-1:0];
            CSR_PATTERN_INDEX_BITS: pat_idx_bits_ff  <= csr_wdata[PIB_W-1:0];
            CSR_ALIAS_SELECT:       alias_ff         <= csr_wdata[ALIAS_W-1:0];
            default:                hist_bits_ff     <= hist_bits_ff;
         endcase
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         pc_ff    <= req_pc[PC_WIDTH-1:0];
         taken_ff <= req_taken;
      end
   end

   // Table indexes from pc bits above bit zero; history mask
   always_comb begin
      for (int i = 0; i < HIW; i++) begin
         hidx[i] = pc_ff[i+1] & (i < int'(hist_idx_bits_ff)) & (i < HISTORY_INDEX_MAX);
      end
      for (int i = 0; i < PIW; i++) begin
         pidx[i] = pc_ff[i+1] & (i < int'(pat_idx_bits_ff)) & (i < PATTERN_INDEX_MAX);
      end
      for (int i = 0; i < HM; i++) begin
         hmask[i] = (i < int'(hist_bits_ff));
      end
   end

   assign hg = (hist_idx_bits_ff == '0) || (HISTORY_INDEX_MAX == 0);
   assign pg = (pat_idx_bits_ff == '0) || (PATTERN_INDEX_MAX == 0);

   // Counter index, aliased with pc when both tables are global
   assign hist_masked = hist_rd_ff & hmask;
   always_comb begin
      cidx = hist_masked;
      if (hg && pg) begin
         case (alias_ff)
            ALIAS_XOR: cidx = (hist_masked ^ pc_ff[HM-1:0]) & hmask;
            ALIAS_AND: cidx = hist_masked & pc_ff[HM-1:0];
            default:   cidx = hist_masked;
         endcase
      end
   end

   assign cnt_addr = {pidx, cidx};
   assign row_addr = {pidx, sweep_ff[HM-1:0]};

   // Saturate the counter toward the outcome; shift the outcome into history
   always_comb begin
      cnt_new = cnt_rd_ff;
      if (taken_ff) begin
         if (cnt_rd_ff != CNT_MAX) begin
            cnt_new = cnt_rd_ff + 2'd1;
         end
      end else if (cnt_rd_ff != '0) begin
         cnt_new = cnt_rd_ff - 2'd1;
      end
   end

   assign hist_new = ((hist_rd_ff << 1) | HM'(taken_ff)) & hmask;

   // Lookup result
   assign hit  = (hg || (htag_rd_ff == pc_ff)) && (pg || (ptag_rd_ff == pc_ff));
   assign pred = (cnt_rd_ff > CNT_WEAK_NT);

   // Sweep counter for the clearing pass and row clears
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_clear) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   assign status.pat_global = pg;
   assign status.sweep_last = &sweep_ff;
   assign status.row_last   = &sweep_ff[HM-1:0];

   // History registers
   always_ff @(posedge clock) begin
      if (cmd.clear_all) begin
         hist_mem[sweep_ff[HIW-1:0]] <= '0;
      end else if (cmd.alloc_write && !hg) begin
         hist_mem[hidx] <= '0;
      end else if (cmd.exec_update) begin
         hist_mem[hidx] <= hist_new;
      end
      hist_rd_ff <= hist_mem[hidx];
   end

   // History tags
   always_ff @(posedge clock) begin
      if (cmd.clear_all) begin
         htag_mem[sweep_ff[HIW-1:0]] <= '0;
      end else if (cmd.alloc_write && !hg) begin
         htag_mem[hidx] <= pc_ff;
      end
      htag_rd_ff <= htag_mem[hidx];
   end

   // Pattern tags
   always_ff @(posedge clock) begin
      if (cmd.clear_all) begin
         ptag_mem[sweep_ff[PIW-1:0]] <= '0;
      end else if (cmd.alloc_write && !pg) begin
         ptag_mem[pidx] <= pc_ff;
      end
      ptag_rd_ff <= ptag_mem[pidx];
   end

   // Pattern counters
   always_ff @(posedge clock) begin
      if (cmd.clear_all) begin
         cnt_mem[sweep_ff[CAW-1:0]] <= '0;
      end else if (cmd.row_clear) begin
         cnt_mem[row_addr] <= '0;
      end else if (cmd.exec_update) begin
         cnt_mem[cnt_addr_ff] <= cnt_new;
      end
      cnt_rd_ff   <= cnt_mem[cnt_addr];
      cnt_addr_ff <= cnt_addr;
   end

   // Result register; non-lookup operations return zeros
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         hit_ff  <= cmd.out_lookup & hit;
         pred_ff <= cmd.out_lookup & pred;
      end
   end

   assign rsp_hit           = hit_ff;
   assign rsp_predict_taken = pred_ff;

endmodule

/* rtl/tlabp_checker.sv */
// Port-level checker for the branch predictor top level, attached by bind.
// Depends on the assertion macros header.
`include "two_level_adaptive_branch_predictor_core_macros.svh"

module tlabp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic rsp_predict_taken
);

   // Reset starts the clearing pass: no beat is taken right after it
   `TLABP_ASSERT_NXT(a_reset_blocks_req, clock, 1'b0, reset, !req_ready,
                     "req_ready high after reset")

   // No stale result survives reset
   `TLABP_ASSERT_NXT(a_reset_drops_rsp, clock, 1'b0, reset, !rsp_valid,
                     "rsp_valid high after reset")

   // One item at a time: an accepted beat closes the input for the next cycle
   `TLABP_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
                     "back-to-back req beats")

   // A stalled result beat holds its payload
   `TLABP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_hit) && $stable(rsp_predict_taken),
                     "rsp beat changed while stalled")

endmodule

bind two_level_adaptive_branch_predictor_core tlabp_checker u_checker (.*);

/* verif/two_level_adaptive_branch_predictor_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-level adaptive branch predictor core.
// Holds its own table model and checks every response beat in order.
// Depends on tlabp_pkg and two_level_adaptive_branch_predictor_core.
module two_level_adaptive_branch_predictor_core_tb;
   import tlabp_pkg::*;

   localparam int HIST_ROWS      = 1 << HIST_INDEX_MAX_DEF;
   localparam int PAT_ROWS       = 1 << PAT_INDEX_MAX_DEF;
   localparam int ROW_LEN        = 1 << HIST_MAX_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_BEATS    = 120;

   // Alias selections that the package leaves unnamed
   localparam logic [ALIAS_W-1:0] ALIAS_HIST   = 2'd0;
   localparam logic [ALIAS_W-1:0] ALIAS_UNUSED = 2'd3;

   typedef struct packed {
      logic hit;
      logic predict_taken;
   } branch_result_t;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op            = OP_LOOKUP;
   logic [PC_FIELD_W-1:0] req_pc            = '0;
   logic                  req_taken         = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic                  rsp_hit;
   logic                  rsp_predict_taken;
   logic                  csr_we            = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = CSR_HISTORY_BITS;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;

   // Predictor copy of the registers and tables
   logic [HB_W-1:0]       cfg_hist_bits  = HB_RESET;
   logic [HIB_W-1:0]      cfg_hist_index = HIB_RESET;
   logic [PIB_W-1:0]      cfg_pat_index  = PIB_RESET;
   logic [ALIAS_W-1:0]    cfg_alias_sel  = ALIAS_RESET;
   logic [HIST_MAX_DEF-1:0] hist_regs [HIST_ROWS];
   logic [PC_FIELD_W-1:0] hist_tags [HIST_ROWS];
   logic [PC_FIELD_W-1:0] pat_tags  [PAT_ROWS];
   logic [1:0]            pat_ctrs  [PAT_ROWS][ROW_LEN];

   branch_result_t        predicted_q [$];
   int                    mismatch_count    = 0;
   int                    idle_cycles       = 0;
   int                    send_idle_pct     = 0;
   int                    recv_idle_pct     = 0;
   int                    hold_cycles_left  = 0;

   two_level_adaptive_branch_predictor_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_pc            (req_pc),
      .req_taken         (req_taken),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_predict_taken (rsp_predict_taken),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Wipe every history, tag and counter
   task automatic clear_tables();
      for (int i = 0; i < HIST_ROWS; i++) begin
         hist_regs[i] = '0;
         hist_tags[i] = '0;
      end
      for (int r = 0; r < PAT_ROWS; r++) begin
         pat_tags[r] = '0;
         for (int c = 0; c < ROW_LEN; c++) begin
            pat_ctrs[r][c] = '0;
         end
      end
   endtask

   // Apply one accepted beat to the tables and queue the response it must give
   task automatic predict_branch(input logic [1:0] op, input logic [PC_FIELD_W-1:0] pc,
                                 input logic tk);
      int             hw, hiw, piw, hmask, hi, pi, ci;
      branch_result_t res;
      hw    = (cfg_hist_bits > HIST_MAX_DEF) ? HIST_MAX_DEF : int'(cfg_hist_bits);
      hiw   = (cfg_hist_index > HIST_INDEX_MAX_DEF) ? HIST_INDEX_MAX_DEF
                                                    : int'(cfg_hist_index);
      piw   = (cfg_pat_index > PAT_INDEX_MAX_DEF) ? PAT_INDEX_MAX_DEF : int'(cfg_pat_index);
      hmask = (1 << hw) - 1;
      hi    = int'(pc[HIST_INDEX_MAX_DEF:1]) & ((1 << hiw) - 1);
      pi    = int'(pc[PAT_INDEX_MAX_DEF:1]) & ((1 << piw) - 1);
      ci    = int'(hist_regs[hi]) & hmask;
      // fold the pc into the history only when both tables are global
      if (hiw == 0 && piw == 0) begin
         if (cfg_alias_sel == ALIAS_XOR) begin
            ci = (ci ^ int'(pc[HIST_MAX_DEF-1:0])) & hmask;
         end else if (cfg_alias_sel == ALIAS_AND) begin
            ci = (ci & int'(pc[HIST_MAX_DEF-1:0])) & hmask;
         end
      end
      res = '0;
      case (op)
         OP_LOOKUP: begin
            res.hit = (hiw == 0 || hist_tags[hi] == pc) && (piw == 0 || pat_tags[pi] == pc);
            res.predict_taken = pat_ctrs[pi][ci] > CNT_WEAK_NT;
         end
         OP_ALLOC: begin
            if (hiw != 0) begin
               hist_tags[hi] = pc;
               hist_regs[hi] = '0;
            end
            if (piw != 0) begin
               pat_tags[pi] = pc;
               for (int c = 0; c < ROW_LEN; c++) begin
                  pat_ctrs[pi][c] = '0;
               end
            end
         end
         OP_UPDATE: begin
            // saturate the counter, then shift the outcome into the history
            if (tk) begin
               if (pat_ctrs[pi][ci] < CNT_MAX) pat_ctrs[pi][ci] = pat_ctrs[pi][ci] + 2'd1;
            end else if (pat_ctrs[pi][ci] != '0) begin
               pat_ctrs[pi][ci] = pat_ctrs[pi][ci] - 2'd1;
            end
            hist_regs[hi] = HIST_MAX_DEF'({hist_regs[hi], tk} & hmask);
         end
         default: begin
            clear_tables();
         end
      endcase
      predicted_q.push_back(res);
   endtask

   // Track request beats, check response beats, and watch for a stuck block
   always @(posedge clock) begin : beat_monitor
      branch_result_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_branch(req_op, req_pc, req_taken);
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_q.size() == 0) begin
               $display("%0t: unexpected response beat: hit %0b predict_taken %0b",
                        $time, rsp_hit, rsp_predict_taken);
               mismatch_count++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: hit mismatch: expected %0b actual %0b",
                           $time, want.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_predict_taken !== want.predict_taken) begin
                  $display("%0t: predict_taken mismatch: expected %0b actual %0b",
                           $time, want.predict_taken, rsp_predict_taken);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Response side: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles_left > 0) begin
         rsp_ready        <= 1'b0;
         hold_cycles_left <= hold_cycles_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_item(input op_type op, input logic [PC_FIELD_W-1:0] pc,
                            input logic tk);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_pc    <= pc;
      req_taken <= tk;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write all four registers back to back; the block must be idle
   task automatic write_config(input logic [CSR_DATA_W-1:0] hb,
                               input logic [CSR_DATA_W-1:0] hib,
                               input logic [CSR_DATA_W-1:0] pib,
                               input logic [ALIAS_W-1:0]    asel);
      csr_beat(CSR_HISTORY_BITS, hb);
      csr_beat(CSR_HISTORY_INDEX_BITS, hib);
      csr_beat(CSR_PATTERN_INDEX_BITS, pib);
      csr_beat(CSR_ALIAS_SELECT, CSR_DATA_W'(asel));
      csr_we         <= 1'b0;
      cfg_hist_bits  = hb[HB_W-1:0];
      cfg_hist_index = hib[HIB_W-1:0];
      cfg_pat_index  = pib[PIB_W-1:0];
      cfg_alias_sel  = asel;
   endtask

   // Reset settings, one global history and row: extreme pcs, saturation, flush
   task automatic test_global_reset_config();
      send_item(OP_LOOKUP, '0, 1'b0);
      send_item(OP_LOOKUP, '1, 1'b1);
      send_item(OP_UPDATE, '0, 1'b1);
      send_item(OP_UPDATE, '0, 1'b1);
      send_item(OP_UPDATE, '1, 1'b1);
      send_item(OP_LOOKUP, '0, 1'b0);
      send_item(OP_ALLOC, '1, 1'b0);
      send_item(OP_UPDATE, '1, 1'b0);
      send_item(OP_LOOKUP, '1, 1'b0);
      send_item(OP_FLUSH, '0, 1'b0);
      send_item(OP_LOOKUP, '0, 1'b0);
   endtask

   // Zero history width, registers above their maxima, tag miss, alias modes
   task automatic test_special_settings();
      logic [PC_FIELD_W-1:0] pc_a, pc_b;
      pc_a = 64'h8000_0000_0000_0012;
      pc_b = pc_a ^ 64'h0000_0100_0000_0000;
      wait_idle();
      write_config(4'd0, 4'd0, 4'd0, ALIAS_XOR);
      send_item(OP_UPDATE, 64'h5, 1'b1);
      send_item(OP_UPDATE, 64'hA, 1'b1);
      send_item(OP_LOOKUP, 64'h5, 1'b0);
      wait_idle();
      write_config(4'd15, 4'd7, 4'd7, ALIAS_UNUSED);
      send_item(OP_ALLOC, pc_a, 1'b0);
      send_item(OP_UPDATE, pc_a, 1'b1);
      send_item(OP_UPDATE, pc_a, 1'b1);
      send_item(OP_LOOKUP, pc_a, 1'b0);
      // same indices, different tag
      send_item(OP_LOOKUP, pc_b, 1'b0);
      send_item(OP_UPDATE, pc_b, 1'b0);
      send_item(OP_LOOKUP, pc_a, 1'b0);
      wait_idle();
      write_config(4'd8, 4'd0, 4'd0, ALIAS_UNUSED);
      send_item(OP_UPDATE, '1, 1'b1);
      send_item(OP_LOOKUP, '1, 1'b0);
      wait_idle();
      write_config(4'd6, 4'd0, 4'd0, ALIAS_AND);
      send_item(OP_LOOKUP, 64'h2A, 1'b0);
      send_item(OP_UPDATE, 64'h2A, 1'b1);
   endtask

   // Stall the response side long enough to back the block up, then pause the sender
   task automatic test_output_backpressure();
      logic [PC_FIELD_W-1:0] pc;
      wait_idle();
      write_config(4'd8, 4'd6, 4'd0, ALIAS_HIST);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pc = {$urandom, $urandom};
      send_item(OP_ALLOC, pc, 1'b0);
      hold_cycles_left <= LONG_HOLD;
      repeat (12) begin
         send_item(OP_UPDATE, pc, 1'b1);
         send_item(OP_LOOKUP, pc, 1'b0);
      end
      wait_idle();
      repeat (4) begin
         send_item(OP_UPDATE, pc, 1'($urandom_range(1)));
         send_item(OP_LOOKUP, pc, 1'b0);
      end
   endtask

   // Mostly allocate-then-train sequences on a small pc pool, with some noise
   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] hb,
                                   input logic [CSR_DATA_W-1:0] hib,
                                   input logic [CSR_DATA_W-1:0] pib,
                                   input logic [ALIAS_W-1:0] asel, input int n_beats);
      logic [PC_FIELD_W-1:0] pool [8];
      int                    bias [8];
      int                    sent, k;
      wait_idle();
      write_config(hb, hib, pib, asel);
      for (int i = 0; i < 8; i++) begin
         pool[i] = {$urandom, $urandom};
         bias[i] = 5 + 45 * int'($urandom_range(2));
      end
      sent = 0;
      while (sent < n_beats) begin
         k = int'($urandom_range(7));
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(99) < 60) begin
               send_item(OP_ALLOC, pool[k], 1'($urandom_range(1)));
               sent++;
            end
            repeat ($urandom_range(2, 8)) begin
               send_item(OP_LOOKUP, pool[k], 1'($urandom_range(1)));
               send_item(OP_UPDATE, pool[k], $urandom_range(99) < bias[k]);
               sent += 2;
            end
         end else begin
            send_item(op_type'($urandom_range(2)), {$urandom, $urandom},
                      1'($urandom_range(1)));
            sent++;
            if ($urandom_range(99) < 15) begin
               send_item(OP_FLUSH, {$urandom, $urandom}, 1'($urandom_range(1)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_configs();
      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 9;
      recv_idle_pct = 80;
      run_random_phase(4'd8, 4'd0, 4'd0, ALIAS_HIST, PHASE_BEATS);
      run_random_phase(4'd8, 4'd0, 4'd0, ALIAS_XOR, PHASE_BEATS);
      run_random_phase(4'd5, 4'd0, 4'd0, ALIAS_AND, PHASE_BEATS);
      run_random_phase(4'd8, 4'd6, 4'd0, ALIAS_HIST, PHASE_BEATS);
      // sender mostly idle, receiver mostly ready
      send_idle_pct = 80;
      recv_idle_pct = 9;
      run_random_phase(4'd3, 4'd0, 4'd4, ALIAS_HIST, PHASE_BEATS);
      run_random_phase(4'd8, 4'd6, 4'd4, ALIAS_HIST, PHASE_BEATS);
      run_random_phase(4'd15, 4'd7, 4'd7, ALIAS_XOR, PHASE_BEATS);
      run_random_phase(4'd0, 4'd3, 4'd2, ALIAS_AND, PHASE_BEATS);
      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(4'd1, 4'd0, 4'd0, ALIAS_UNUSED, PHASE_BEATS);
      run_random_phase(4'd4, 4'd2, 4'd1, ALIAS_HIST, PHASE_BEATS);
      run_random_phase(4'd2, 4'd1, 4'd3, ALIAS_UNUSED, PHASE_BEATS);
      run_random_phase(CSR_DATA_W'($urandom_range(15)), CSR_DATA_W'($urandom_range(7)),
                       CSR_DATA_W'($urandom_range(7)), ALIAS_W'($urandom_range(3)),
                       PHASE_BEATS);
   endtask

   initial begin
      clear_tables();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // hold off until the power-on clearing pass is done
      do @(posedge clock); while (!req_ready);
      test_global_reset_config();
      test_special_settings();
      test_output_backpressure();
      test_random_configs();
      wait_idle();
      if (mismatch_count == 0 && predicted_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
